/* hw/rtl/cht_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Chained hash table package
// Shared sizes, operation and status codes, and the transaction payload types.
// ----------------------------------------------------------------------------
package cht_pkg;

   localparam int Buckets    = 64;
   localparam int Nodes      = 256;
   localparam int BucketBits = $clog2(Buckets);
   localparam int NodeBits   = $clog2(Nodes);
   localparam int LinkBits   = NodeBits + 1;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_FIND   = 2'd1,
      OP_DELETE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL     = 2'd2,
      ST_UNUSED   = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] key_bytes;
      logic [3:0]  key_length;
      logic [63:0] value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] value_out;
      logic [8:0]  entry_total;
   } rsp_type;

   // Node record as kept in the node memory.
   typedef struct packed {
      logic [63:0]         key;
      logic [3:0]          len;
      logic [63:0]         value;
      logic [LinkBits-1:0] link;
   } node_type;

endpackage : cht_pkg
`default_nettype wire

/* hw/rtl/cht_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cht_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule : cht_ram
`default_nettype wire

/* hw/rtl/chained_hash_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Chained hash table
// Key-value store with chained buckets over a fixed node pool.
// ----------------------------------------------------------------------------
// One transaction at a time. After the accepting cycle, a lookup hashes the key
// character by character, reduces the hash modulo the bucket count, reads the
// bucket head, walks the chain one node memory read at a time, then decides,
// finishes and raises the response. A clear refills the free list memory
// before it responds. After reset the block runs a clearing pass over the free
// list memory, and it accepts no request transaction until it ends. The next
// request can be taken while the previous response still waits in the output
// register; the new response then waits until the output register is free.
module chained_hash_table (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire cht_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output cht_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [6:0]       csr_data
);
   import cht_pkg::*;

   typedef enum logic [13:0] {
      S_INIT   = 14'b00000000000001,
      S_IDLE   = 14'b00000000000010,
      S_HASH   = 14'b00000000000100,
      S_MOD    = 14'b00000000001000,
      S_HEAD   = 14'b00000000010000,
      S_HEADW  = 14'b00000000100000,
      S_NODE   = 14'b00000001000000,
      S_NODEW  = 14'b00000010000000,
      S_DECIDE = 14'b00000100000000,
      S_CURW   = 14'b00001000000000,
      S_FREEW  = 14'b00010000000000,
      S_FIN    = 14'b00100000000000,
      S_CLEAR  = 14'b01000000000000,
      S_OUT    = 14'b10000000000000
   } state_type;

   localparam logic [LinkBits-1:0] EndLink = LinkBits'(Nodes);

   state_type state_ff, state_in;
   logic [6:0]  bcount_ff, bcount_in;
   logic [1:0]  op_ff, op_in;
   logic [63:0] key_ff, key_in;
   logic [3:0]  len_ff, len_in;
   logic [63:0] val_ff, val_in;
   logic [3:0]  idx_ff, idx_in;
   logic [31:0] hash_ff, hash_in;
   logic [6:0]  bc_ff, bc_in;
   logic [2:0]  mstep_ff, mstep_in;
   logic [BucketBits-1:0] bucket_ff, bucket_in;
   logic [LinkBits-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic [LinkBits-1:0] headv_ff, headv_in;
   logic [LinkBits:0]   steps_ff, steps_in;
   logic [LinkBits-1:0] free_top_ff, free_top_in;
   logic [8:0]  count_ff, count_in;
   logic [NodeBits-1:0] sweep_ff, sweep_in;
   logic [Buckets-1:0]  hvalid_ff, hvalid_in;
   node_type    curnode_ff, curnode_in;
   rsp_type     res_ff, res_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rspv_ff, rspv_in;

   // Bucket head memory.
   logic                  hd_we;
   logic [BucketBits-1:0] hd_wa, hd_ra;
   logic [LinkBits-1:0]   hd_wd, hd_rd;
   // Node memory.
   logic                  nd_we;
   logic [NodeBits-1:0]   nd_wa, nd_ra;
   node_type              nd_wd, nd_rd;
   // Free list memory.
   logic                  fr_we;
   logic [NodeBits-1:0]   fr_wa, fr_ra;
   logic [NodeBits-1:0]   fr_wd, fr_rd;

   cht_ram #(.Width(LinkBits), .Depth(Buckets)) u_heads (
      .clock, .wr_en(hd_we), .wr_addr(hd_wa), .wr_data(hd_wd),
      .rd_addr(hd_ra), .rd_data(hd_rd));
   cht_ram #(.Width($bits(node_type)), .Depth(Nodes)) u_nodes (
      .clock, .wr_en(nd_we), .wr_addr(nd_wa), .wr_data(nd_wd),
      .rd_addr(nd_ra), .rd_data(nd_rd));
   cht_ram #(.Width(NodeBits), .Depth(Nodes)) u_free (
      .clock, .wr_en(fr_we), .wr_addr(fr_wa), .wr_data(fr_wd),
      .rd_addr(fr_ra), .rd_data(fr_rd));

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

   logic [63:0] kmask;
   logic [3:0]  klen;
   logic        kon;
   logic [7:0]  kbyte;
   logic        found;
   logic [LinkBits-1:0] headval;

   // Effective key: clamp the length and stop at the first zero byte.
   always_comb begin
      klen  = (req_data.key_length > 4'd8) ? 4'd8 : req_data.key_length;
      kmask = '0;
      kon   = 1'b1;
      for (int i = 0; i < 8; i++) begin
         kon = kon && (4'(i) < klen) && (req_data.key_bytes[8*i +: 8] != 8'd0);
         if (kon) begin
            kmask[8*i +: 8] = 8'hFF;
         end
      end
   end

   assign kbyte = key_ff[{idx_ff[2:0], 3'b000} +: 8];
   assign headval = hvalid_ff[bucket_ff] ? hd_rd : EndLink;
   assign found = (nd_rd.len == len_ff) && (nd_rd.key == key_ff);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      bcount_in = csr_valid ? csr_data : bcount_ff;
      op_in = op_ff; key_in = key_ff; len_in = len_ff; val_in = val_ff;
      idx_in = idx_ff; hash_in = hash_ff; bc_in = bc_ff; mstep_in = mstep_ff;
      bucket_in = bucket_ff; cur_in = cur_ff; prev_in = prev_ff;
      headv_in = headv_ff; steps_in = steps_ff; free_top_in = free_top_ff;
      count_in = count_ff; sweep_in = sweep_ff; hvalid_in = hvalid_ff;
      curnode_in = curnode_ff; res_in = res_ff; rsp_in = rsp_ff;
      rspv_in = rspv_ff && rsp_stall;
      hd_we = 1'b0; hd_wa = bucket_ff; hd_wd = EndLink; hd_ra = bucket_ff;
      nd_we = 1'b0; nd_wa = cur_ff[NodeBits-1:0]; nd_wd = curnode_ff;
      nd_ra = cur_ff[NodeBits-1:0];
      fr_we = 1'b0; fr_wa = sweep_ff; fr_wd = sweep_ff;
      fr_ra = NodeBits'(free_top_ff - LinkBits'(1));
      case (state_ff)
         S_INIT: begin
            fr_we = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == NodeBits'(Nodes - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in  = req_data.operation;
               key_in = req_data.key_bytes & kmask;
               len_in = '0;
               for (int i = 0; i < 8; i++) begin
                  len_in = len_in + {3'd0, kmask[8*i]};
               end
               val_in = req_data.value_in;
               idx_in = '0;
               hash_in = 32'd1;
               sweep_in = '0;
               bc_in = (bcount_ff == 7'd0) ? 7'd1 :
                       (bcount_ff > 7'(Buckets)) ? 7'(Buckets) : bcount_ff;
               state_in = (req_data.operation == OP_CLEAR) ? S_CLEAR : S_HASH;
            end
         end
         // One key character per cycle.
         S_HASH: begin
            if (idx_ff == len_ff) begin
               mstep_in = '0;
               state_in = S_MOD;
            end else begin
               hash_in = hash_ff * 32'd19 + {24'd0, kbyte};
               idx_in = idx_ff + 1'b1;
            end
         end
         // Restoring remainder, four bits per cycle over 32 bits.
         S_MOD: begin
            for (int j = 3; j >= 0; j--) begin
               if ({7'd0, hash_in} >=
                   ({32'd0, bc_ff} << {3'd7 - mstep_ff, 2'(j)})) begin
                  hash_in = hash_in -
                     32'({32'd0, bc_ff} << {3'd7 - mstep_ff, 2'(j)});
               end
            end
            mstep_in = mstep_ff + 1'b1;
            if (mstep_ff == 3'd7) begin
               state_in = S_HEAD;
            end
         end
         // Issue the bucket head read.
         S_HEAD: begin
            bucket_in = hash_ff[BucketBits-1:0];
            hd_ra = hash_ff[BucketBits-1:0];
            state_in = S_HEADW;
         end
         S_HEADW: begin
            headv_in = headval;
            cur_in = headval;
            prev_in = EndLink;
            steps_in = '0;
            state_in = S_NODE;
         end
         // Chain walk: issue read, then compare.
         S_NODE: begin
            if (cur_ff == EndLink) begin
               state_in = S_DECIDE;
            end else begin
               state_in = S_NODEW;
            end
         end
         S_NODEW: begin
            curnode_in = nd_rd;
            if (found) begin
               state_in = S_DECIDE;
            end else begin
               prev_in = cur_ff;
               cur_in = nd_rd.link;
               steps_in = steps_ff + 1'b1;
               state_in = (steps_ff + 1'b1 >= (LinkBits+1)'(Nodes)) ? S_DECIDE : S_NODE;
               if (steps_ff + 1'b1 >= (LinkBits+1)'(Nodes)) begin
                  cur_in = EndLink;
               end
            end
         end
         S_DECIDE: begin
            res_in.status = ST_OK;
            res_in.value_out = '0;
            state_in = S_FIN;
            if (op_ff == OP_FIND) begin
               if (cur_ff != EndLink) res_in.value_out = curnode_ff.value;
               else res_in.status = ST_NOT_FOUND;
            end else if (op_ff == OP_INSERT) begin
               if (cur_ff != EndLink) begin
                  nd_we = 1'b1;
                  nd_wd = curnode_ff;
                  nd_wd.value = val_ff;
               end else if (free_top_ff == '0) begin
                  res_in.status = ST_FULL;
               end else begin
                  state_in = S_FREEW;
               end
            end else begin
               if (cur_ff == EndLink) begin
                  res_in.status = ST_NOT_FOUND;
               end else begin
                  if (prev_ff == EndLink) begin
                     hd_we = 1'b1;
                     hd_wd = curnode_ff.link;
                     hvalid_in[bucket_ff] = 1'b1;
                     state_in = S_CURW;
                  end else begin
                     nd_ra = prev_ff[NodeBits-1:0];
                     state_in = S_CURW;
                  end
               end
            end
         end
         // Delete: relink predecessor, free the node.
         S_CURW: begin
            if (prev_ff != EndLink) begin
               nd_we = 1'b1;
               nd_wa = prev_ff[NodeBits-1:0];
               nd_wd = nd_rd;
               nd_wd.link = curnode_ff.link;
            end
            if (free_top_ff < EndLink) begin
               fr_we = 1'b1;
               fr_wa = free_top_ff[NodeBits-1:0];
               fr_wd = cur_ff[NodeBits-1:0];
               free_top_in = free_top_ff + 1'b1;
            end
            if (count_ff != '0) count_in = count_ff - 1'b1;
            state_in = S_FIN;
         end
         // Insert: pop a free node and link at the head.
         S_FREEW: begin
            nd_we = 1'b1;
            nd_wa = fr_rd;
            nd_wd.key = key_ff;
            nd_wd.len = len_ff;
            nd_wd.value = val_ff;
            nd_wd.link = headv_ff;
            hd_we = 1'b1;
            hd_wd = {1'b0, fr_rd};
            hvalid_in[bucket_ff] = 1'b1;
            free_top_in = free_top_ff - 1'b1;
            count_in = count_ff + 1'b1;
            state_in = S_FIN;
         end
         // Clear: empty every bucket and refill the free list, one entry a cycle.
         S_CLEAR: begin
            fr_we = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            hvalid_in = '0;
            free_top_in = EndLink;
            count_in = '0;
            res_in.status = ST_OK;
            res_in.value_out = '0;
            if (sweep_ff == NodeBits'(Nodes - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            res_in.entry_total = count_ff;
            state_in = S_OUT;
         end
         // Hand the result to the output register once it is free.
         S_OUT: begin
            if (!rspv_ff || !rsp_stall) begin
               rspv_in = 1'b1;
               rsp_in = res_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         bcount_ff <= 7'd64;
         free_top_ff <= EndLink;
         count_ff <= '0;
         sweep_ff <= '0;
         hvalid_ff <= '0;
         rspv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bcount_ff <= bcount_in;
         free_top_ff <= free_top_in;
         count_ff <= count_in;
         sweep_ff <= sweep_in;
         hvalid_ff <= hvalid_in;
         rspv_ff <= rspv_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff <= op_in; key_ff <= key_in; len_ff <= len_in; val_ff <= val_in;
      idx_ff <= idx_in; hash_ff <= hash_in; bc_ff <= bc_in;
      mstep_ff <= mstep_in; bucket_ff <= bucket_in; cur_ff <= cur_in;
      prev_ff <= prev_in; headv_ff <= headv_in; steps_ff <= steps_in;
      curnode_ff <= curnode_in; res_ff <= res_in; rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   // The entry count never exceeds the pool size.
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 9'(Nodes)) else $error("entry count overflow");
   // In the idle state, free stack depth and entry count sum to the pool size.
   a_pool: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> (9'(free_top_ff) + count_ff) == 9'(Nodes))
      else $error("pool accounting broken");
   // A response is only raised from the output state.
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_OUT) else $error("stray response");
`endif

endmodule : chained_hash_table
`default_nettype wire

/* tb/chained_hash_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash table testbench
// Drives insert, find, delete and clear transactions against a local model
// of the chained table and compares every response field by field.
// ----------------------------------------------------------------------------
module chained_hash_table_tb;
   import cht_pkg::*;

   localparam int CycleLimit = 2000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [6:0] csr_data = '0;

   chained_hash_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Local copy of the table state.
   logic [6:0]  tbl_buckets;
   logic [8:0]  tbl_heads [Buckets];
   logic [63:0] tbl_keys [Nodes];
   logic [3:0]  tbl_lens [Nodes];
   logic [63:0] tbl_vals [Nodes];
   logic [8:0]  tbl_links [Nodes];
   logic [7:0]  tbl_free [Nodes];
   int          tbl_free_top;
   int          tbl_entries;

   rsp_type expected_rsps [$];
   int      errors = 0;
   int      cycles = 0;
   bit      hold_off = 1'b0;
   logic [63:0] key_pool [8];

   // Empty all buckets and refill the node pool.
   function automatic void empty_table();
      for (int i = 0; i < Buckets; i++) tbl_heads[i] = 9'(Nodes);
      for (int i = 0; i < Nodes; i++) tbl_free[i] = 8'(i);
      tbl_free_top = Nodes;
      tbl_entries = 0;
   endfunction

   // Compute the response of one request and update the local table.
   function automatic rsp_type table_apply(req_type r);
      rsp_type     o;
      int          len, bc, b, cur, prv, steps, n;
      logic [63:0] kb;
      logic [31:0] h;
      o = '0;
      len = (r.key_length > 8) ? 8 : int'(r.key_length);
      kb = r.key_bytes;
      begin : trim
         for (int i = 0; i < 8; i++) begin
            if (i >= len) break;
            if (kb[8*i +: 8] == 8'h00) begin
               len = i;
               break;
            end
         end
      end
      for (int i = 0; i < 8; i++) if (i >= len) kb[8*i +: 8] = 8'h00;
      bc = int'(tbl_buckets);
      if (bc == 0) bc = 1;
      if (bc > Buckets) bc = Buckets;
      h = 32'd1;
      for (int i = 0; i < len; i++) h = h * 32'd19 + 32'(kb[8*i +: 8]);
      b = int'(h % 32'(bc));
      if (op_type'(r.operation) == OP_CLEAR) begin
         empty_table();
      end else begin
         // Walk the chain, keeping the predecessor for delete.
         prv = Nodes;
         cur = tbl_heads[b];
         steps = 0;
         while (cur < Nodes && steps < Nodes) begin
            if (int'(tbl_lens[cur]) == len && tbl_keys[cur] == kb) break;
            prv = cur;
            cur = tbl_links[cur];
            steps++;
         end
         if (steps >= Nodes) cur = Nodes;
         case (op_type'(r.operation))
            OP_INSERT: begin
               if (cur < Nodes) tbl_vals[cur] = r.value_in;
               else if (tbl_free_top == 0) o.status = ST_FULL;
               else begin
                  tbl_free_top--;
                  n = tbl_free[tbl_free_top];
                  tbl_keys[n] = kb;
                  tbl_lens[n] = 4'(len);
                  tbl_vals[n] = r.value_in;
                  tbl_links[n] = tbl_heads[b];
                  tbl_heads[b] = 9'(n);
                  tbl_entries++;
               end
            end
            OP_FIND: begin
               if (cur < Nodes) o.value_out = tbl_vals[cur];
               else o.status = ST_NOT_FOUND;
            end
            default: begin
               if (cur < Nodes) begin
                  if (prv < Nodes) tbl_links[prv] = tbl_links[cur];
                  else tbl_heads[b] = tbl_links[cur];
                  tbl_links[cur] = 9'(Nodes);
                  if (tbl_free_top < Nodes) begin
                     tbl_free[tbl_free_top] = 8'(cur);
                     tbl_free_top++;
                  end
                  if (tbl_entries > 0) tbl_entries--;
               end else begin
                  o.status = ST_NOT_FOUND;
               end
            end
         endcase
      end
      o.entry_total = 9'(tbl_entries);
      return o;
   endfunction

   // Send one request transaction after a random gap. The valid of the
   // previous transaction is dropped at the first falling edge unless the
   // next one follows at once.
   task automatic send_request(op_type op, logic [63:0] kb, logic [3:0] len,
                               logic [63:0] val);
      req_type r;
      int      gap;
      gap = $urandom_range(0, 18);
      if ($urandom_range(0, 3) == 0) gap = 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      r.operation = op;
      r.key_bytes = kb;
      r.key_length = len;
      r.value_in = val;
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_rsps.push_back(table_apply(r));
   endtask

   // Wait until every response is in, plus the block's worst latency.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (600) @(negedge clock);
   endtask

   task automatic write_bucket_count(logic [6:0] v);
      drain();
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      tbl_buckets = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Key with random non-zero bytes, drawn from a small pool to force hits.
   function automatic logic [63:0] pool_key();
      return key_pool[$urandom_range(0, 7)];
   endfunction

   function automatic logic [63:0] random_key();
      logic [63:0] k;
      for (int i = 0; i < 8; i++) k[8*i +: 8] = 8'($urandom_range(1, 255));
      return k;
   endfunction

   task automatic test_directed();
      send_request(OP_FIND, 64'h0, 4'd0, 64'h0);
      send_request(OP_INSERT, 64'h0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(OP_FIND, 64'hFFFF, 4'd0, 64'h0);
      send_request(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'h1234);
      send_request(OP_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h0);
      send_request(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h0);
      send_request(OP_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 64'hFFFF);
      // A zero byte ends the key early.
      send_request(OP_INSERT, 64'h4400_4241, 4'd4, 64'h55);
      send_request(OP_FIND, 64'h0000_4241, 4'd2, 64'h0);
      send_request(OP_DELETE, 64'h0101_0101, 4'd4, 64'h0);
      send_request(OP_DELETE, 64'h0000_4241, 4'd3, 64'h0);
      send_request(OP_DELETE, 64'h0, 4'd0, 64'h0);
      send_request(OP_CLEAR, 64'h0, 4'd0, 64'h0);
      send_request(OP_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h0);
   endtask

   // Eight keys; at a bucket count of one, one bucket holds every key: long chains, deletes of head, middle and tail.
   task automatic test_single_bucket(logic [6:0] bc);
      write_bucket_count(bc);
      for (int i = 0; i < 8; i++) send_request(OP_INSERT, key_pool[i], 4'd8, 64'(i));
      send_request(OP_DELETE, key_pool[0], 4'd8, 64'h0);
      send_request(OP_DELETE, key_pool[7], 4'd8, 64'h0);
      send_request(OP_DELETE, key_pool[3], 4'd8, 64'h0);
      for (int i = 0; i < 8; i++) send_request(OP_FIND, key_pool[i], 4'd8, 64'h0);
   endtask

   // Fill the pool past capacity, then empty it again.
   task automatic test_pool_full();
      for (int i = 0; i < Nodes + 4; i++)
         send_request(OP_INSERT, random_key(), 4'($urandom_range(1, 8)),
                      {$urandom, $urandom});
      send_request(OP_INSERT, random_key(), 4'd8, 64'h1);
      send_request(OP_CLEAR, 64'h0, 4'd0, 64'h0);
   endtask

   // Random mix over a small key pool, under one bucket setting.
   task automatic test_random(logic [6:0] bc, int count);
      logic [63:0] k;
      int          sel;
      write_bucket_count(bc);
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         k = ($urandom_range(0, 9) < 8) ? pool_key() : {$urandom, $urandom};
         if (sel < 40)
            send_request(OP_INSERT, k, 4'($urandom_range(0, 15)), {$urandom, $urandom});
         else if (sel < 70)
            send_request(OP_FIND, k, 4'($urandom_range(0, 15)), {$urandom, $urandom});
         else if (sel < 97)
            send_request(OP_DELETE, k, 4'($urandom_range(0, 15)), {$urandom, $urandom});
         else
            send_request(OP_CLEAR, k, 4'($urandom_range(0, 15)), {$urandom, $urandom});
      end
   endtask

   // Hold off responses while requests keep coming, so the input backs up.
   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         begin
            repeat (400) @(negedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 6; i++) send_request(OP_FIND, pool_key(), 4'd8, 64'h0);
      join
   endtask

   // Response side: random stalls, then field-by-field comparison.
   initial begin : response_check
      rsp_type want;
      int      wait_cycles;
      forever begin
         @(negedge clock);
         if (hold_off) rsp_stall <= 1'b1;
         else begin
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (wait_cycles != 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_cycles) @(negedge clock);
            end
            while (hold_off) @(negedge clock);
            rsp_stall <= 1'b0;
            do @(posedge clock); while (!rsp_valid);
            if (expected_rsps.size() == 0) begin
               $error("response with none expected");
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.value_out !== want.value_out) begin
                  $error("value_out: expected %h, got %h", want.value_out,
                         rsp_data.value_out);
                  errors++;
               end
               if (rsp_data.entry_total !== want.entry_total) begin
                  $error("entry_total: expected %0d, got %0d", want.entry_total,
                         rsp_data.entry_total);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      tbl_buckets = 7'd64;
      empty_table();
      for (int i = 0; i < 8; i++) key_pool[i] = random_key();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_single_bucket(7'd1);
      test_random(7'd0, 40);
      test_random(7'd127, 40);
      test_backpressure();
      test_random(7'd3, 50);
      test_pool_full();
      test_random(7'd64, 60);
      test_random(7'd17, 40);
      test_single_bucket(7'd64);
      drain();
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
